// ----- rtl/core/lds_pkg.sv -----
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types, commands and constants of the direction sampler.
// ----------------------------------------------------------------------------
package lds_pkg;

    localparam int OUT_W = 18;
    localparam int CX_W  = 34;
    localparam int CZ_W  = 33;

    localparam logic [31:0] LCG_MUL     = 32'd1103515245;
    localparam logic [31:0] LCG_ADD     = 32'd12345;
    localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

    // Rotation angles in binary turns, 2^32 per turn.
    localparam logic [29:0] ATAN_TURNS [32] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
        30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
        30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
        30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
        30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
        30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005,
        30'h00000003, 30'h00000001, 30'h00000001, 30'h00000000
    };

    typedef enum logic [2:0] {
        CMD_RESEED  = 3'd0,
        CMD_UNIFORM = 3'd1,
        CMD_SPHERE  = 3'd2,
        CMD_HEMI    = 3'd3,
        CMD_COSINE  = 3'd4,
        CMD_CAP     = 3'd5
    } t_cmd;

    typedef struct packed {
        logic            valid;
        logic [1:0]      quad;
        logic [CX_W-1:0] x;
        logic [CX_W-1:0] y;
        logic [CZ_W-1:0] z;
    } t_cordic_beat;

    function automatic logic [31:0] lcg_next(input logic [31:0] s);
        return s * LCG_MUL + LCG_ADD;
    endfunction

endpackage

// ----- rtl/core/lcg_direction_sampler.sv -----
// ----------------------------------------------------------------------------
// lcg_direction_sampler
// LCG driven sampler of uniforms and unit directions.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carries a command beat (cmd, seed,
// cap cosine). Output channel: o_out_valid / i_out_stall carries one result
// beat (uniform value and the x, y, z direction components in Q1.FRAC_BITS).
// The block works on one command at a time. Reseed loads the generator and
// gives no beat; a uniform result is held in S_DONE until the output register
// is free. A direction steps the LCG in S_IDLE and S_STEP2, sets up in S_CT
// and S_OPND, runs the bit-serial square root (twice for the cosine-weighted
// hemisphere), then multiplies and rounds in S_MUL and S_FIN. The CORDIC
// cell row runs alongside the square root, and S_WAITC waits for its result.
// Reset clears the generator state to zero.
// When the receiver stalls, the finished beat is held in the output register
// while the next command is taken and worked on; that command's result then
// waits until the output register is free.
// ----------------------------------------------------------------------------
module lcg_direction_sampler import lds_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [2:0]              i_cmd,
    input  logic [31:0]             i_seed_value,
    input  logic signed [OUT_W-1:0] i_cap_cos_alpha,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [31:0]             o_uniform_value,
    output logic signed [OUT_W-1:0] o_dir_x,
    output logic signed [OUT_W-1:0] o_dir_y,
    output logic signed [OUT_W-1:0] o_dir_z
);

    localparam int F     = FRAC_BITS;
    localparam int ONE_W = F + 1;
    localparam int CT_W  = F + 2;
    localparam int SQ_W  = 2 * F + 2;
    localparam int PW    = CX_W + CT_W;
    localparam int SH_W  = PW - 30;
    localparam int CA_W  = (F + 3 > 19) ? F + 3 : 19;

    localparam logic signed [CA_W-1:0] ONE_CA = CA_W'(1) << F;
    localparam logic signed [CT_W-1:0] ONE_CT = CT_W'(1) << F;
    localparam logic [ONE_W-1:0]       ONE_U  = ONE_W'(1) << F;
    localparam logic signed [SH_W-1:0] ONE_SH = SH_W'(1) << F;
    localparam logic signed [PW-1:0]   RND    = PW'(1) << 29;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_STEP2 = 9'b000000010,
        S_CT    = 9'b000000100,
        S_OPND  = 9'b000001000,
        S_ROOT  = 9'b000010000,
        S_WAITC = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state                  r_state;
    logic [31:0]             r_gen;
    logic [31:0]             r_u2;
    t_cmd                    r_cmd;
    logic [CT_W-1:0]         r_d;
    logic signed [CT_W-1:0]  r_ct;
    logic [F-1:0]            r_sq;
    logic                    r_pass;
    logic [ONE_W-1:0]        r_st;
    logic signed [CX_W-1:0]  r_cph;
    logic signed [CX_W-1:0]  r_sph;
    logic                    r_cs_ok;
    logic signed [PW-1:0]    r_px;
    logic signed [PW-1:0]    r_py;
    logic [31:0]             r_res_uniform;
    logic [OUT_W-1:0]        r_res_x;
    logic [OUT_W-1:0]        r_res_y;
    logic [OUT_W-1:0]        r_res_z;
    logic                    r_out_valid;
    logic [31:0]             r_o_uniform;
    logic [OUT_W-1:0]        r_o_x;
    logic [OUT_W-1:0]        r_o_y;
    logic [OUT_W-1:0]        r_o_z;

    logic                    in_accept;
    logic                    out_free;
    logic [31:0]             n_lcg;
    logic                    cs_start;
    t_cordic_beat            cs_beat;
    logic signed [CX_W-1:0]  cs_x;
    logic signed [CX_W-1:0]  cs_y;
    logic signed [CX_W-1:0]  n_cph;
    logic signed [CX_W-1:0]  n_sph;
    logic signed [CA_W-1:0]  ca_ext;
    logic signed [CA_W-1:0]  ca_clamp;
    logic signed [CA_W-1:0]  cap_d;
    logic [CT_W+31:0]        cap_prod;
    logic signed [CT_W-1:0]  n_ct;
    logic signed [CT_W-1:0]  ct_abs;
    logic [SQ_W-1:0]         a_sq;
    logic [SQ_W-1:0]         opnd_dir;
    logic [SQ_W-1:0]         opnd_cos1;
    logic [SQ_W-1:0]         opnd_cos2;
    logic                    sq_start;
    logic [SQ_W-1:0]         sq_opnd;
    logic                    sq_done;
    logic [ONE_W-1:0]        sq_root;
    logic signed [PW-1:0]    sum_x;
    logic signed [PW-1:0]    sum_y;
    logic signed [SH_W-1:0]  sh_x;
    logic signed [SH_W-1:0]  sh_y;
    logic signed [SH_W-1:0]  cl_x;
    logic signed [SH_W-1:0]  cl_y;
    logic signed [OUT_W+SH_W-1:0] ext_x;
    logic signed [OUT_W+SH_W-1:0] ext_y;
    logic signed [OUT_W+CT_W-1:0] ext_z;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign n_lcg      = lcg_next(r_gen);
    assign cs_start   = in_accept && (i_cmd >= CMD_SPHERE) && (i_cmd <= CMD_CAP);

    lds_cordic_chain #(
        .STAGES(CORDIC_STAGES)
    ) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(cs_start),
        .i_phi  (n_lcg),
        .o_beat (cs_beat)
    );

    // The chain covers one quadrant; the top two angle bits rotate the result.
    assign cs_x = $signed(cs_beat.x);
    assign cs_y = $signed(cs_beat.y);
    always_comb begin
        case (cs_beat.quad)
            2'd0:    begin n_cph = cs_x;  n_sph = cs_y;  end
            2'd1:    begin n_cph = -cs_y; n_sph = cs_x;  end
            2'd2:    begin n_cph = -cs_x; n_sph = -cs_y; end
            default: begin n_cph = cs_y;  n_sph = -cs_x; end
        endcase
    end

    // Cap cosine saturated to [-1, 1]; the distance from one is kept.
    assign ca_ext   = CA_W'(i_cap_cos_alpha);
    assign ca_clamp = (ca_ext > ONE_CA) ? ONE_CA : ((ca_ext < -ONE_CA) ? -ONE_CA : ca_ext);
    assign cap_d    = ONE_CA - ca_clamp;

    assign cap_prod = (CT_W + 32)'(r_d) * (CT_W + 32)'(r_u2);

    always_comb begin
        case (r_cmd)
            CMD_SPHERE: n_ct = ONE_CT - $signed({1'b0, r_u2[31 -: ONE_W]});
            CMD_HEMI:   n_ct = $signed({2'b00, r_u2[31 -: F]});
            default:    n_ct = ONE_CT - $signed(cap_prod[CT_W+31:32]);
        endcase
    end

    assign ct_abs    = r_ct[CT_W-1] ? -r_ct : r_ct;
    assign a_sq      = SQ_W'(ct_abs[ONE_W-1:0]) * SQ_W'(ct_abs[ONE_W-1:0]);
    assign opnd_dir  = (SQ_W'(1) << (2 * F)) - a_sq;
    assign opnd_cos1 = SQ_W'(r_sq) << F;
    assign opnd_cos2 = SQ_W'(ONE_U - ONE_W'(r_sq)) << F;

    assign sq_start = (r_state == S_OPND)
                   || ((r_state == S_ROOT) && sq_done && (r_cmd == CMD_COSINE) && !r_pass);
    assign sq_opnd  = (r_state == S_OPND) ? ((r_cmd == CMD_COSINE) ? opnd_cos1 : opnd_dir)
                                          : opnd_cos2;

    lds_isqrt #(
        .W(SQ_W)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_opnd (sq_opnd),
        .o_done (sq_done),
        .o_root (sq_root)
    );

    // Round half up, drop 30 fraction bits, then clamp to [-1, 1].
    assign sum_x = r_px + RND;
    assign sum_y = r_py + RND;
    assign sh_x  = sum_x[PW-1:30];
    assign sh_y  = sum_y[PW-1:30];
    assign cl_x  = (sh_x > ONE_SH) ? ONE_SH : ((sh_x < -ONE_SH) ? -ONE_SH : sh_x);
    assign cl_y  = (sh_y > ONE_SH) ? ONE_SH : ((sh_y < -ONE_SH) ? -ONE_SH : sh_y);
    assign ext_x = (OUT_W + SH_W)'(cl_x);
    assign ext_y = (OUT_W + SH_W)'(cl_y);
    assign ext_z = (OUT_W + CT_W)'(r_ct);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gen       <= '0;
            r_cs_ok     <= 1'b0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cs_beat.valid) begin
                r_cs_ok <= 1'b1;
                r_cph   <= n_cph;
                r_sph   <= n_sph;
            end
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        unique case (i_cmd)
                            CMD_RESEED: begin
                                r_gen <= i_seed_value;
                            end
                            CMD_UNIFORM: begin
                                r_gen         <= n_lcg;
                                r_res_uniform <= n_lcg;
                                r_res_x       <= '0;
                                r_res_y       <= '0;
                                r_res_z       <= '0;
                                r_state       <= S_DONE;
                            end
                            CMD_SPHERE, CMD_HEMI, CMD_COSINE, CMD_CAP: begin
                                r_gen   <= n_lcg;
                                r_cmd   <= t_cmd'(i_cmd);
                                r_d     <= cap_d[CT_W-1:0];
                                r_cs_ok <= 1'b0;
                                r_state <= S_STEP2;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_STEP2: begin
                    r_gen   <= n_lcg;
                    r_u2    <= n_lcg;
                    r_state <= S_CT;
                end
                S_CT: begin
                    r_ct    <= n_ct;
                    r_sq    <= r_u2[31 -: F];
                    r_state <= S_OPND;
                end
                S_OPND: begin
                    r_pass  <= 1'b0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (sq_done) begin
                        if ((r_cmd == CMD_COSINE) && !r_pass) begin
                            // First root of the cosine case is the polar cosine itself.
                            r_ct   <= $signed({1'b0, sq_root});
                            r_pass <= 1'b1;
                        end else begin
                            r_st    <= sq_root;
                            r_state <= S_WAITC;
                        end
                    end
                end
                S_WAITC: begin
                    if (r_cs_ok) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_px    <= PW'(r_cph) * PW'($signed({1'b0, r_st}));
                    r_py    <= PW'(r_sph) * PW'($signed({1'b0, r_st}));
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res_uniform <= '0;
                    r_res_x       <= ext_x[OUT_W-1:0];
                    r_res_y       <= ext_y[OUT_W-1:0];
                    r_res_z       <= ext_z[OUT_W-1:0];
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_uniform <= r_res_uniform;
                        r_o_x       <= r_res_x;
                        r_o_y       <= r_res_y;
                        r_o_z       <= r_res_z;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_uniform_value = r_o_uniform;
    assign o_dir_x         = $signed(r_o_x);
    assign o_dir_y         = $signed(r_o_y);
    assign o_dir_z         = $signed(r_o_z);

endmodule

// ----- rtl/core/lds_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// lds_cordic_cell
// One registered CORDIC rotation stage with a fixed shift and angle.
// ----------------------------------------------------------------------------
module lds_cordic_cell import lds_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cordic_beat i_beat,
    output t_cordic_beat o_beat
);

    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic [CZ_W-1:0]        at;
    t_cordic_beat           n_beat;
    t_cordic_beat           r_beat;

    assign dx = $signed(i_beat.y) >>> STAGE;
    assign dy = $signed(i_beat.x) >>> STAGE;
    assign at = CZ_W'(ATAN_TURNS[STAGE]);

    always_comb begin
        n_beat = i_beat;
        if (!i_beat.z[CZ_W-1]) begin
            n_beat.x = i_beat.x - dx;
            n_beat.y = i_beat.y + dy;
            n_beat.z = i_beat.z - at;
        end else begin
            n_beat.x = i_beat.x + dx;
            n_beat.y = i_beat.y - dy;
            n_beat.z = i_beat.z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.quad <= n_beat.quad;
        r_beat.x    <= n_beat.x;
        r_beat.y    <= n_beat.y;
        r_beat.z    <= n_beat.z;
    end

    assign o_beat = r_beat;

endmodule

// ----- rtl/core/lds_cordic_chain.sv -----
// ----------------------------------------------------------------------------
// lds_cordic_chain
// Row of CORDIC cells giving cos and sin of the first quadrant angle.
// ----------------------------------------------------------------------------
module lds_cordic_chain import lds_pkg::*; #(
    parameter int STAGES = 18
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [31:0]  i_phi,
    output t_cordic_beat o_beat
);

    t_cordic_beat beats [STAGES+1];

    assign beats[0].valid = i_start;
    assign beats[0].quad  = i_phi[31:30];
    assign beats[0].x     = CX_W'(CORDIC_GAIN);
    assign beats[0].y     = '0;
    assign beats[0].z     = CZ_W'(i_phi[29:0]);

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        lds_cordic_cell #(
            .STAGE(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_beat (beats[g]),
            .o_beat (beats[g+1])
        );
    end

    assign o_beat = beats[STAGES];

endmodule

// ----- rtl/core/lds_isqrt.sv -----
// ----------------------------------------------------------------------------
// lds_isqrt
// Floored integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lds_isqrt #(
    parameter int W = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_opnd,
    output logic             o_done,
    output logic [W/2-1:0]   o_root
);

    localparam int STEPS = W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [W-1:0]     r_v;
    logic [W-1:0]     r_r;
    logic [W-1:0]     r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [W:0]       trial;

    assign trial = {1'b0, r_r} + {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_opnd;
                r_r    <= '0;
                r_b    <= W'(1) << (W - 2);
                r_cnt  <= CNT_W'(STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if ({1'b0, r_v} >= trial) begin
                    r_v <= r_v - trial[W-1:0];
                    r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b   <= r_b >> 2;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[STEPS-1:0];

endmodule
